@@ hdl/mcg_pkg.sv @@
// Shared types, constants and calendar helper functions for the month calendar grid.
// No dependencies; imported by every other file of the block.
`default_nettype none

package mcg_pkg;

    localparam int MCG_YEAR_W    = 14;
    localparam int MCG_MONTH_W   = 4;
    localparam int MCG_DAY_W     = 5;
    localparam int MCG_PART_W    = 2;
    localparam int MCG_GRID_ROWS = 6;
    localparam int MCG_COLS      = 7;
    localparam int MCG_QDEPTH    = 2;

    localparam logic [MCG_YEAR_W-1:0]  MCG_YEAR_MIN  = 14'd1900;
    localparam logic [MCG_YEAR_W-1:0]  MCG_YEAR_MAX  = 14'd9999;
    localparam logic [MCG_MONTH_W-1:0] MCG_MONTH_JAN = 4'd1;
    localparam logic [MCG_MONTH_W-1:0] MCG_MONTH_FEB = 4'd2;
    localparam logic [MCG_MONTH_W-1:0] MCG_MONTH_DEC = 4'd12;

    // Grid cell owner codes
    localparam logic [MCG_PART_W-1:0] MCG_PART_PREV = 2'd0;
    localparam logic [MCG_PART_W-1:0] MCG_PART_CUR  = 2'd1;
    localparam logic [MCG_PART_W-1:0] MCG_PART_NEXT = 2'd2;

    // Per-page descriptor handed from the front end to the cell generator
    typedef struct packed {
        logic [2:0]           lead;        // previous-month cells before day 1
        logic [MCG_DAY_W-1:0] this_len;    // length of the requested month
        logic [MCG_DAY_W-1:0] prev_first;  // first previous-month day shown
    } t_mcg_desc;

    // Month length; month 0 is December of the year before
    function automatic logic [MCG_DAY_W-1:0] mcg_month_len(
        input logic [MCG_MONTH_W-1:0] m,
        input logic                   leap
    );
        logic [MCG_DAY_W-1:0] len;
        case (m) inside
            MCG_MONTH_FEB:              len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:    len = 5'd30;
            default:                    len = 5'd31;
        endcase
        return len;
    endfunction

    // Zeller month term floor(26*(mm+1)/10), January and February as 13 and 14
    function automatic logic [5:0] mcg_zeller_term(input logic [MCG_MONTH_W-1:0] m);
        logic [5:0] t;
        case (m)
            4'd1:    t = 6'd36;
            4'd2:    t = 6'd39;
            4'd3:    t = 6'd10;
            4'd4:    t = 6'd13;
            4'd5:    t = 6'd15;
            4'd6:    t = 6'd18;
            4'd7:    t = 6'd20;
            4'd8:    t = 6'd23;
            4'd9:    t = 6'd26;
            4'd10:   t = 6'd28;
            4'd11:   t = 6'd31;
            default: t = 6'd33;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

@@ hdl/mcg_ifs.sv @@
// Handshake interfaces for the request channel and the grid cell channel.
// Depends on mcg_pkg for field widths.
`default_nettype none

interface mcg_req_if
    import mcg_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [MCG_YEAR_W-1:0]  year;
    logic [MCG_MONTH_W-1:0] month;

    modport source (output valid, output year, output month, input ready);
    modport sink   (input valid, input year, input month, output ready);
endinterface

interface mcg_cell_if
    import mcg_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [MCG_DAY_W-1:0]  day_number;
    logic [MCG_PART_W-1:0] month_part;
    logic                  last_cell;

    modport source (output valid, output day_number, output month_part, output last_cell,
                    input ready);
    modport sink   (input valid, input day_number, input month_part, input last_cell,
                    output ready);
endinterface

`default_nettype wire

@@ hdl/month_calendar_grid_core.sv @@
// Month calendar grid: one request (Gregorian year, month) in, GRID_ROWS*7 grid cells out,
// Monday first, in row order. Each cell carries the day shown, which month it belongs to
// (previous, requested, next) and a flag on the final cell. Years outside 1900..9999 and
// months outside 1..12 are clamped. The front end is a six-stage pipeline that clamps the
// request, finds the weekday of the first with Zeller's congruence (divisions by 100 and 7
// done as reciprocal multiplies) and the month lengths; its page descriptor goes through a
// two-entry queue to the cell generator, which emits one cell per cycle, while the cell
// channel is not stalled, into a registered output. Grids follow each other with no gap
// while requests keep coming. The request channel keeps accepting while cells still drain,
// until the queue and the front pipeline fill. There is no configuration and no state
// beyond the items in flight. Depends on mcg_pkg, mcg_ifs, mcg_front, mcg_fifo, mcg_back.
`default_nettype none

module month_calendar_grid_core
    import mcg_pkg::*;
#(
    parameter int GRID_ROWS = MCG_GRID_ROWS
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mcg_req_if.sink    i_req,
    mcg_cell_if.source o_cell
);

    // front end to queue
    t_mcg_desc w_f_desc;
    logic      w_f_valid;
    logic      w_f_ready;

    // queue to cell generator
    t_mcg_desc w_q_desc;
    logic      w_q_valid;
    logic      w_q_ready;

    // clamp, classify and compute the page descriptor
    mcg_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .o_desc       (w_f_desc),
        .o_desc_valid (w_f_valid),
        .i_desc_ready (w_f_ready)
    );

    // decouple descriptor production from cell emission
    mcg_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_desc       (w_f_desc),
        .i_push_valid (w_f_valid),
        .o_push_ready (w_f_ready),
        .o_desc       (w_q_desc),
        .o_pop_valid  (w_q_valid),
        .i_pop_ready  (w_q_ready)
    );

    // walk the grid, one cell per cycle while the cell channel is not stalled
    mcg_back #(
        .GRID_ROWS (GRID_ROWS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_desc       (w_q_desc),
        .i_desc_valid (w_q_valid),
        .o_desc_ready (w_q_ready),
        .o_cell       (o_cell)
    );

endmodule

`default_nettype wire

@@ hdl/mcg_front.sv @@
// Front end: accepts requests, clamps them and works out the page descriptor
// (leading days, month length, first previous-month day). Depends on mcg_pkg, mcg_ifs.
`default_nettype none

module mcg_front
    import mcg_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mcg_req_if.sink    i_req,
    output t_mcg_desc  o_desc,
    output logic       o_desc_valid,
    input  wire logic  i_desc_ready
);

    logic w_en;

    // stage 0: clamped request
    logic                   r0_v;
    logic [MCG_YEAR_W-1:0]  r0_y;
    logic [MCG_MONTH_W-1:0] r0_m;
    logic [MCG_YEAR_W-1:0]  n0_y;
    logic [MCG_MONTH_W-1:0] n0_m;

    // stage 1: year times reciprocal of 100
    logic                   r1_v;
    logic [26:0]            r1_prod;
    logic [MCG_YEAR_W-1:0]  r1_y;
    logic [MCG_MONTH_W-1:0] r1_m;

    // stage 2: century and year of century
    logic                   r2_v;
    logic [6:0]             r2_cy;
    logic [6:0]             r2_ry;
    logic [1:0]             r2_y4;
    logic [MCG_MONTH_W-1:0] r2_m;
    logic [6:0]             n2_cy;
    logic [MCG_YEAR_W-1:0]  w2_hund;
    logic [MCG_YEAR_W-1:0]  w2_rem;

    // stage 3: Zeller sum and month lengths
    logic                 r3_v;
    logic [9:0]           r3_s;
    logic [MCG_DAY_W-1:0] r3_len;
    logic [MCG_DAY_W-1:0] r3_plen;
    logic                 w3_leap;
    logic                 w3_jf;
    logic [6:0]           w3_rz;
    logic [6:0]           w3_cz;
    logic [9:0]           w3_s;

    // stage 4: sum times reciprocal of 7
    logic                 r4_v;
    logic [18:0]          r4_prod;
    logic [9:0]           r4_s;
    logic [MCG_DAY_W-1:0] r4_len;
    logic [MCG_DAY_W-1:0] r4_plen;

    // stage 5: descriptor
    logic                 r5_v;
    t_mcg_desc            r5_desc;
    logic [7:0]           w5_q;
    logic [9:0]           w5_h;
    logic [2:0]           w5_lead;

    // advance the whole pipe unless the descriptor at the end is blocked
    assign w_en        = !r5_v || i_desc_ready;
    assign i_req.ready = w_en;

    always_comb begin
        n0_y = i_req.year;
        if (i_req.year < MCG_YEAR_MIN) begin
            n0_y = MCG_YEAR_MIN;
        end else if (i_req.year > MCG_YEAR_MAX) begin
            n0_y = MCG_YEAR_MAX;
        end
        n0_m = i_req.month;
        if (i_req.month < MCG_MONTH_JAN) begin
            n0_m = MCG_MONTH_JAN;
        end else if (i_req.month > MCG_MONTH_DEC) begin
            n0_m = MCG_MONTH_DEC;
        end
    end

    // floor(y/100) = (y*5243)>>19 exactly for y up to 9999
    assign n2_cy   = r1_prod[25:19];
    assign w2_hund = MCG_YEAR_W'(n2_cy) * 14'd100;
    assign w2_rem  = r1_y - w2_hund;

    always_comb begin
        w3_leap = ((r2_y4 == 2'd0) && (r2_ry != 7'd0)) ||
                  ((r2_ry == 7'd0) && (r2_cy[1:0] == 2'd0));
        w3_jf   = (r2_m <= MCG_MONTH_FEB);
        // January and February belong to the year before
        w3_rz   = r2_ry;
        w3_cz   = r2_cy;
        if (w3_jf) begin
            if (r2_ry == 7'd0) begin
                w3_rz = 7'd99;
                w3_cz = r2_cy - 7'd1;
            end else begin
                w3_rz = r2_ry - 7'd1;
            end
        end
        w3_s = 10'(w3_rz) + 10'(w3_rz[6:2]) + 10'(w3_cz[6:2]) + 10'(w3_cz) * 10'd5
             + 10'(mcg_zeller_term(r2_m));
    end

    // floor(s/7) = (s*293)>>11 exactly for s up to 684; the sum never exceeds 681
    assign w5_q    = r4_prod[18:11];
    assign w5_h    = r4_s - 10'(w5_q) * 10'd7;
    assign w5_lead = (w5_h[2:0] == 3'd0) ? 3'd6 : (w5_h[2:0] - 3'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else if (w_en) begin
            r0_v <= i_req.valid;
            r1_v <= r0_v;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_y    <= n0_y;
            r0_m    <= n0_m;

            r1_prod <= 27'(r0_y) * 27'd5243;
            r1_y    <= r0_y;
            r1_m    <= r0_m;

            r2_cy   <= n2_cy;
            r2_ry   <= w2_rem[6:0];
            r2_y4   <= r1_y[1:0];
            r2_m    <= r1_m;

            r3_s    <= w3_s;
            r3_len  <= mcg_month_len(r2_m, w3_leap);
            r3_plen <= mcg_month_len(r2_m - 4'd1, w3_leap);

            r4_prod <= 19'(r3_s) * 19'd293;
            r4_s    <= r3_s;
            r4_len  <= r3_len;
            r4_plen <= r3_plen;

            r5_desc.lead       <= w5_lead;
            r5_desc.this_len   <= r4_len;
            r5_desc.prev_first <= r4_plen - MCG_DAY_W'(w5_lead) + 5'd1;
        end
    end

    assign o_desc       = r5_desc;
    assign o_desc_valid = r5_v;

endmodule

`default_nettype wire

@@ hdl/mcg_fifo.sv @@
// Short descriptor queue between the front end and the cell generator.
// Depends on mcg_pkg for the descriptor type and depth.
`default_nettype none

module mcg_fifo
    import mcg_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_mcg_desc i_desc,
    input  wire logic      i_push_valid,
    output logic           o_push_ready,
    output t_mcg_desc      o_desc,
    output logic           o_pop_valid,
    input  wire logic      i_pop_ready
);

    localparam int AW = (MCG_QDEPTH > 1) ? $clog2(MCG_QDEPTH) : 1;
    localparam int CW = $clog2(MCG_QDEPTH + 1);

    t_mcg_desc       r_mem [MCG_QDEPTH];
    logic [AW-1:0]   r_wp;
    logic [AW-1:0]   r_rp;
    logic [CW-1:0]   r_cnt;
    logic            w_push;
    logic            w_pop;

    assign o_push_ready = (r_cnt != CW'(MCG_QDEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;
    assign o_desc       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == AW'(MCG_QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == AW'(MCG_QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_desc;
        end
    end

endmodule

`default_nettype wire

@@ hdl/mcg_back.sv @@
// Cell generator: walks one page descriptor per grid, one cell a cycle while the cell
// channel is not stalled, into a registered output. Depends on mcg_pkg, mcg_ifs.
`default_nettype none

module mcg_back
    import mcg_pkg::*;
#(
    parameter int GRID_ROWS = MCG_GRID_ROWS
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_mcg_desc i_desc,
    input  wire logic      i_desc_valid,
    output logic           o_desc_ready,
    mcg_cell_if.source     o_cell
);

    localparam int TOTAL = GRID_ROWS * MCG_COLS;
    localparam int KW    = $clog2(TOTAL);

    logic                  r_busy;
    logic [KW-1:0]         r_k;
    logic [2:0]            r_lead;
    logic [MCG_DAY_W-1:0]  r_len;
    logic [MCG_DAY_W-1:0]  r_prev;
    logic [MCG_DAY_W-1:0]  r_cur;
    logic [MCG_DAY_W-1:0]  r_nxt;

    logic                  r_o_v;
    logic [MCG_DAY_W-1:0]  r_o_day;
    logic [MCG_PART_W-1:0] r_o_part;
    logic                  r_o_last;

    logic                  w_adv;
    logic                  w_fin;
    logic                  w_load;
    logic [MCG_DAY_W-1:0]  n_day;
    logic [MCG_PART_W-1:0] n_part;

    assign w_adv        = !r_o_v || o_cell.ready;
    assign w_fin        = r_busy && (r_k == KW'(TOTAL - 1));
    // take the next descriptor as the last cell leaves, so grids run back to back
    assign w_load       = w_adv && (!r_busy || w_fin) && i_desc_valid;
    assign o_desc_ready = w_adv && (!r_busy || w_fin);

    always_comb begin
        if (r_lead != 3'd0) begin
            n_day  = r_prev;
            n_part = MCG_PART_PREV;
        end else if (r_len != '0) begin
            n_day  = r_cur;
            n_part = MCG_PART_CUR;
        end else begin
            n_day  = r_nxt;
            n_part = MCG_PART_NEXT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_o_v  <= 1'b0;
            r_k    <= '0;
        end else if (w_adv) begin
            r_o_v <= r_busy;
            if (w_load) begin
                r_busy <= 1'b1;
                r_k    <= '0;
            end else if (w_fin) begin
                r_busy <= 1'b0;
            end else if (r_busy) begin
                r_k <= r_k + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (r_busy) begin
                r_o_day  <= n_day;
                r_o_part <= n_part;
                r_o_last <= w_fin;
            end
            if (w_load) begin
                r_lead <= i_desc.lead;
                r_len  <= i_desc.this_len;
                r_prev <= i_desc.prev_first;
                r_cur  <= 5'd1;
                r_nxt  <= 5'd1;
            end else if (r_busy) begin
                if (r_lead != 3'd0) begin
                    r_lead <= r_lead - 3'd1;
                    r_prev <= r_prev + 5'd1;
                end else if (r_len != '0) begin
                    r_len <= r_len - 5'd1;
                    r_cur <= r_cur + 5'd1;
                end else begin
                    r_nxt <= r_nxt + 5'd1;
                end
            end
        end
    end

    assign o_cell.valid      = r_o_v;
    assign o_cell.day_number = r_o_day;
    assign o_cell.month_part = r_o_part;
    assign o_cell.last_cell  = r_o_last;

    // a shown day is never zero
    a_day_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_v |-> (r_o_day != '0))
        else $error("grid cell with day zero");

    // previous-month days are always from the closing week of that month
    a_prev_late: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_v && (r_o_part == MCG_PART_PREV)) |-> (r_o_day >= 5'd23))
        else $error("previous-month day out of closing week");

    // a grid of six or more rows always ends in next-month days
    a_last_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_v && r_o_last) |-> (r_o_part == MCG_PART_NEXT))
        else $error("last cell not in next month");

    // never more than six leading previous-month cells to walk
    a_lead_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_lead <= 3'd6))
        else $error("leading cell count out of range");

endmodule

`default_nettype wire
